// ===== rtl/core/sirt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sirt_pkg
// shared constants, types and the reciprocal table of the radix text block
// ----------------------------------------------------------------------------
package sirt_pkg;

    localparam int MAX_SYMBOLS = 16;
    localparam int VALUE_BITS  = 32;

    localparam int RADIX_W = 5;
    localparam int SYM_W   = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int DIG_W   = $clog2(VALUE_BITS);
    localparam int CNT_W   = $clog2(VALUE_BITS + 1);
    localparam int RECIP_W = 32;
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 2;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    localparam logic [IDX_W-1:0] REG_RADIX_SIZE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

    typedef logic [7:0] t_byte;
    typedef t_byte [MAX_SYMBOLS-1:0] t_alphabet;

    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        t_alphabet          symbols;
    } t_cfg;

    typedef struct packed {
        logic                  neg;
        logic [VALUE_BITS-1:0] mag;
    } t_job;

    // floor(2^32 / n), exact quotient is this estimate or one more
    function automatic logic [RECIP_W-1:0] recip(input logic [RADIX_W-1:0] n);
        logic [RECIP_W-1:0] r;
        unique case (n)
            5'd2:    r = 32'h8000_0000;
            5'd3:    r = 32'h5555_5555;
            5'd4:    r = 32'h4000_0000;
            5'd5:    r = 32'h3333_3333;
            5'd6:    r = 32'h2AAA_AAAA;
            5'd7:    r = 32'h2492_4924;
            5'd8:    r = 32'h2000_0000;
            5'd9:    r = 32'h1C71_C71C;
            5'd10:   r = 32'h1999_9999;
            5'd11:   r = 32'h1745_D174;
            5'd12:   r = 32'h1555_5555;
            5'd13:   r = 32'h13B1_3B13;
            5'd14:   r = 32'h1249_2492;
            5'd15:   r = 32'h1111_1111;
            5'd16:   r = 32'h1000_0000;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sirt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sirt_front
// accepts values, checks the alphabet and hands sign and magnitude to the queue
// ----------------------------------------------------------------------------
module sirt_front (
    input  wire logic                 i_tvalid,
    output logic                      o_tready,
    input  wire logic [31:0]          i_tdata,
    input  wire sirt_pkg::t_cfg       i_cfg,
    input  wire logic                 i_full,
    output logic                      o_push,
    output sirt_pkg::t_job            o_job
);
    import sirt_pkg::*;

    logic                  w_ok;
    logic [VALUE_BITS-1:0] w_val;

    always_comb begin
        w_ok = (i_cfg.radix >= 5'd2) && (i_cfg.radix <= RADIX_W'(MAX_SYMBOLS));
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (RADIX_W'(i) < i_cfg.radix) begin
                if (i_cfg.symbols[i] == CH_PLUS || i_cfg.symbols[i] == CH_MINUS) begin
                    w_ok = 1'b0;
                end
                for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
                    if (RADIX_W'(j) < i_cfg.radix && i_cfg.symbols[i] == i_cfg.symbols[j]) begin
                        w_ok = 1'b0;
                    end
                end
            end
        end
    end

    assign w_val     = i_tdata[VALUE_BITS-1:0];
    assign o_tready  = !i_full;
    assign o_push    = i_tvalid && !i_full && w_ok;
    assign o_job.neg = w_val[VALUE_BITS-1];
    assign o_job.mag = w_val[VALUE_BITS-1] ? (~w_val + 1'b1) : w_val;

endmodule
`default_nettype wire

// ===== rtl/core/sirt_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sirt_queue
// two-entry queue of requests between the front and back parts
// ----------------------------------------------------------------------------
module sirt_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire sirt_pkg::t_job i_job,
    output logic                o_full,
    output logic                o_valid,
    input  wire logic           i_pop,
    output sirt_pkg::t_job      o_job
);
    import sirt_pkg::*;

    t_job       r_ent [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_ent[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= !r_wr;
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_ent[r_wr] <= i_job;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/sirt_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sirt_back
// reciprocal divider producing digits, then byte emitter with output register
// ----------------------------------------------------------------------------
module sirt_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire sirt_pkg::t_cfg i_cfg,
    input  wire logic           i_job_valid,
    input  wire sirt_pkg::t_job i_job,
    output logic                o_pop,
    output logic                o_tvalid,
    input  wire logic           i_tready,
    output logic [7:0]          o_tdata,
    output logic                o_tlast
);
    import sirt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_SIGN,
        S_DIGIT
    } t_state;

    t_state                        r_state;
    logic                          r_neg;
    logic [VALUE_BITS-1:0]         r_mag;
    logic [VALUE_BITS-1:0]         r_qest;
    logic [CNT_W-1:0]              r_nd;
    logic [SYM_W-1:0]              r_dig [VALUE_BITS];
    logic                          r_tvalid;
    logic [7:0]                    r_tdata;
    logic                          r_tlast;

    logic [VALUE_BITS+RECIP_W-1:0] w_prod;
    logic [VALUE_BITS+RADIX_W-1:0] w_qn;
    logic [VALUE_BITS-1:0]         w_rem;
    logic [VALUE_BITS-1:0]         w_n;
    logic [VALUE_BITS-1:0]         w_q;
    logic [VALUE_BITS-1:0]         w_d;
    logic [CNT_W-1:0]              w_rd;
    logic                          w_out_free;
    logic                          w_emit;

    assign w_prod     = {{RECIP_W{1'b0}}, r_mag} * {{VALUE_BITS{1'b0}}, recip(i_cfg.radix)};
    assign w_qn       = {{RADIX_W{1'b0}}, r_qest} * {{VALUE_BITS{1'b0}}, i_cfg.radix};
    assign w_n        = {{(VALUE_BITS-RADIX_W){1'b0}}, i_cfg.radix};
    assign w_rem      = r_mag - w_qn[VALUE_BITS-1:0];
    assign w_q        = (w_rem >= w_n) ? r_qest + 1'b1 : r_qest;
    assign w_d        = (w_rem >= w_n) ? w_rem - w_n : w_rem;
    assign w_rd       = r_nd - 1'b1;
    assign w_out_free = !r_tvalid || i_tready;
    assign w_emit     = ((r_state == S_SIGN) || (r_state == S_DIGIT)) && w_out_free;

    assign o_pop    = (r_state == S_IDLE) && i_job_valid;
    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tvalid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_tvalid <= 1'b1;
            end else if (i_tready) begin
                r_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_neg   <= i_job.neg;
                        r_mag   <= i_job.mag;
                        r_nd    <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_qest  <= w_prod[VALUE_BITS+RECIP_W-1:RECIP_W];
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_dig[r_nd[DIG_W-1:0]] <= w_d[SYM_W-1:0];
                    r_nd  <= r_nd + 1'b1;
                    r_mag <= w_q;
                    if (w_q == '0) begin
                        r_state <= r_neg ? S_SIGN : S_DIGIT;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_SIGN: begin
                    if (w_out_free) begin
                        r_tdata  <= CH_MINUS;
                        r_tlast  <= 1'b0;
                        r_state  <= S_DIGIT;
                    end
                end
                S_DIGIT: begin
                    if (w_out_free) begin
                        r_tdata  <= i_cfg.symbols[r_dig[w_rd[DIG_W-1:0]]];
                        r_tlast  <= (r_nd == CNT_W'(1));
                        r_nd     <= w_rd;
                        if (r_nd == CNT_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/signed_int_to_radix_text.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_radix_text
// signed integer to text in a configured radix and alphabet
// ----------------------------------------------------------------------------
// the reciprocal divider takes a multiply and a divide state per digit, then
// the output register sends one byte per cycle while the receiver is ready,
// a minus sign first for negative values; the next value is taken only
// after the last byte of the one before has been emitted
// two values queue ahead of the divider; invalid alphabets drop the value
// reset clears the configuration registers to zero, the queue and output valid
// ----------------------------------------------------------------------------
module signed_int_to_radix_text (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [sirt_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire logic [sirt_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [31:0]                   s_axis_tdata,  // value
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [7:0]                         m_axis_tdata,  // text_byte
    output logic                               m_axis_tlast
);
    import sirt_pkg::*;

    logic [RADIX_W-1:0] r_radix;
    logic [CFG_W-1:0]   r_sym_lo;
    logic [CFG_W-1:0]   r_sym_hi;
    t_cfg               w_cfg;
    logic               w_full;
    logic               w_push;
    t_job               w_in_job;
    logic               w_job_valid;
    logic               w_pop;
    t_job               w_out_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= '0;
            r_sym_lo <= '0;
            r_sym_hi <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_RADIX_SIZE:   r_radix  <= i_cfg_data[RADIX_W-1:0];
                REG_SYMBOLS_LOW:  r_sym_lo <= i_cfg_data;
                REG_SYMBOLS_HIGH: r_sym_hi <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_cfg.radix = r_radix;
        for (int k = 0; k < MAX_SYMBOLS; k++) begin
            if (k < 8) begin
                w_cfg.symbols[k] = r_sym_lo[8*k +: 8];
            end else begin
                w_cfg.symbols[k] = r_sym_hi[8*(k-8) +: 8];
            end
        end
    end

    sirt_front u_front (
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_cfg    (w_cfg),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_job    (w_in_job)
    );

    sirt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_in_job),
        .o_full  (w_full),
        .o_valid (w_job_valid),
        .i_pop   (w_pop),
        .o_job   (w_out_job)
    );

    sirt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_job_valid (w_job_valid),
        .i_job       (w_out_job),
        .o_pop       (w_pop),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata),
        .o_tlast     (m_axis_tlast)
    );

endmodule
`default_nettype wire

// ===== rtl/core/sirt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sirt_checker
// port-level checks of the radix text block, bound to the top level
// ----------------------------------------------------------------------------
module sirt_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast
);

    a_reset_clears_out : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_ready_falls_on_request : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("input ready dropped without a request");

    a_out_valid_held : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_out_data_held : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output payload changed while stalled");

endmodule

bind signed_int_to_radix_text sirt_checker u_sirt_checker (.*);
`default_nettype wire

// ===== verif/tb_signed_int_to_radix_text.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_radix_text
// self-checking bench for the signed integer to radix text converter
// predictor keeps its own radix and alphabet, checks bytes in order
// directed extremes and broken alphabets, then random values and alphabets
// ----------------------------------------------------------------------------
module tb_signed_int_to_radix_text;

    import sirt_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 300;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    class t_radix_text_scoreboard;
        logic [RADIX_W-1:0] radix;
        logic [CFG_W-1:0]   sym_lo;
        logic [CFG_W-1:0]   sym_hi;
        t_text_char         expected_chars[$];
        int                 errors;
        int                 chars_checked;
        int                 values_seen;
        int                 values_dropped;

        function new();
            radix  = '0;
            sym_lo = '0;
            sym_hi = '0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_RADIX_SIZE:   radix  = data[RADIX_W-1:0];
                REG_SYMBOLS_LOW:  sym_lo = data;
                REG_SYMBOLS_HIGH: sym_hi = data;
                default: ;
            endcase
        endfunction

        function logic [7:0] symbol(int unsigned k);
            return (k < 8) ? sym_lo[8*k +: 8] : sym_hi[8*(k-8) +: 8];
        endfunction

        function bit alphabet_ok();
            int unsigned n;
            n = radix;
            if (n < 2 || n > MAX_SYMBOLS) return 0;
            for (int unsigned i = 0; i < n; i++) begin
                if (symbol(i) == CH_PLUS || symbol(i) == CH_MINUS) return 0;
                for (int unsigned j = i + 1; j < n; j++)
                    if (symbol(i) == symbol(j)) return 0;
            end
            return 1;
        endfunction

        function void note_value(logic [31:0] value);
            logic [31:0]  mag;
            int unsigned  n;
            int unsigned  digits[$];
            bit           neg;
            t_text_char   c;
            values_seen++;
            if (!alphabet_ok()) begin
                values_dropped++;
                return;
            end
            n   = radix;
            neg = value[31];
            mag = neg ? (~value + 32'd1) : value;
            do begin
                digits.push_front(mag % n);
                mag = mag / n;
            end while (mag != 0);
            if (neg) begin
                c.ch   = CH_MINUS;
                c.last = 1'b0;
                expected_chars.push_back(c);
            end
            foreach (digits[i]) begin
                c.ch   = symbol(digits[i]);
                c.last = (i == digits.size() - 1);
                expected_chars.push_back(c);
            end
        endfunction

        function void check_char(logic [7:0] ch, logic last);
            t_text_char want;
            chars_checked++;
            if (expected_chars.size() == 0) begin
                $error("text_byte %02h arrived with nothing expected", ch);
                errors++;
                return;
            end
            want = expected_chars.pop_front();
            if (ch !== want.ch) begin
                $error("text_byte expected %02h got %02h", want.ch, ch);
                errors++;
            end
            if (last !== want.last) begin
                $error("last expected %0b got %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [IDX_W-1:0]     i_cfg_index   = '0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;
    logic                 m_axis_tlast;

    t_radix_text_scoreboard text_check = new();
    logic [31:0]          batch[$];
    int                   send_gap_pct   = 36;
    int                   recv_stall_pct = 72;
    int                   settings_used  = 0;
    int                   quiet_cycles   = 0;

    signed_int_to_radix_text u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // output side: check accepted characters, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            text_check.check_char(m_axis_tdata, m_axis_tlast);
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("signed_int_to_radix_text verification failed");
                $finish;
            end
        end
    end

    task automatic configure(input logic [RADIX_W-1:0] radix, input logic [CFG_W-1:0] lo,
                             input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] data[3];
        logic [IDX_W-1:0] idx[3];
        idx  = '{REG_RADIX_SIZE, REG_SYMBOLS_LOW, REG_SYMBOLS_HIGH};
        data = '{CFG_W'(radix), lo, hi};
        for (int k = 0; k < 3; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= data[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            text_check.write_reg(idx[k], data[k]);
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_value(input logic [31:0] value);
        // three stages of idling: sender light, then receiver light, then none
        if (text_check.values_seen < 85) begin
            send_gap_pct   = 36;
            recv_stall_pct = 72;
        end else if (text_check.values_seen < 170) begin
            send_gap_pct   = 72;
            recv_stall_pct = 36;
        end else begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
        end
        if ($urandom_range(0, 99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_gap_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        text_check.note_value(value);
    endtask

    task automatic run_phase(input logic [RADIX_W-1:0] radix, input logic [CFG_W-1:0] lo,
                             input logic [CFG_W-1:0] hi);
        configure(radix, lo, hi);
        foreach (batch[i]) send_value(batch[i]);
        s_axis_tvalid <= 1'b0;
        while (text_check.expected_chars.size() != 0) @(posedge i_clk);
        // let any stray bytes of dropped values arrive and be flagged
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void make_alphabet(input bit valid, output logic [RADIX_W-1:0] radix,
                                          output logic [CFG_W-1:0] lo,
                                          output logic [CFG_W-1:0] hi);
        bit [255:0]  used;
        logic [7:0]  sym[16];
        logic [7:0]  b;
        int          n;
        int          i;
        int          j;
        used = '0;
        used[CH_PLUS]  = 1'b1;
        used[CH_MINUS] = 1'b1;
        if ($urandom_range(0, 3) == 0)
            n = $urandom_range(0, 1) ? 2 : 16;
        else
            n = $urandom_range(2, 16);
        for (int k = 0; k < 16; k++) begin
            if (k < n) begin
                do b = 8'($urandom); while (used[b]);
                used[b] = 1'b1;
            end else begin
                b = 8'($urandom);
            end
            sym[k] = b;
        end
        if (n < 16 && $urandom_range(0, 1))
            sym[n] = $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
        if (!valid) begin
            case ($urandom_range(0, 3))
                0: n = $urandom_range(0, 1);
                1: sym[$urandom_range(0, n - 1)] = CH_PLUS;
                2: sym[$urandom_range(0, n - 1)] = CH_MINUS;
                default: begin
                    i = $urandom_range(0, n - 2);
                    j = $urandom_range(i + 1, n - 1);
                    sym[j] = sym[i];
                end
            endcase
        end
        for (int k = 0; k < 8; k++) begin
            lo[8*k +: 8] = sym[k];
            hi[8*k +: 8] = sym[k + 8];
        end
        radix = RADIX_W'(n);
    endfunction

    function automatic logic [31:0] pick_value(input int unsigned n);
        longint      p;
        int          k;
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = $urandom;
            2:    v = $urandom_range(0, 40);
            3:    v = 32'd0 - $urandom_range(0, 40);
            4: begin
                // around a power of the radix, where the digit count steps
                p = 1;
                k = $urandom_range(1, 31);
                repeat (k) if (p * n <= 64'h8000_0000) p = p * n;
                v = 32'(p + $urandom_range(0, 2) - 1);
                if ($urandom_range(0, 1)) v = -v;
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    default: v = 32'h0000_0000;
                endcase
            end
        endcase
        return v;
    endfunction

    initial begin
        logic [RADIX_W-1:0] radix;
        logic [CFG_W-1:0]   lo;
        logic [CFG_W-1:0]   hi;
        bit                 valid;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers still at reset: empty alphabet
        batch = '{32'd5, 32'h8000_0000};
        run_phase(5'd0, 64'h0, 64'h0);

        // decimal text
        batch = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000};
        run_phase(5'd10, 64'h3736_3534_3332_3130, 64'h0000_0000_0000_3938);

        // binary with zero and all-ones bytes as symbols, signs in unused slots
        batch = '{32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        run_phase(5'd2, 64'h2B2D_2B2D_2B2D_FF00, 64'hFFFF_FFFF_FFFF_FFFF);

        // full sixteen-symbol alphabet
        batch = '{32'h8000_0000, 32'hDEAD_BEEF, 32'h7FFF_FFFF};
        run_phase(5'd16, 64'h3736_3534_3332_3130, 64'h6665_6463_6261_3938);

        // broken alphabets: single symbol, plus, minus, repeat
        batch = '{32'd42};
        run_phase(5'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        batch = '{32'hFFFF_FFD6};
        run_phase(5'd3, 64'h0000_0000_0062_2B61, 64'h0);
        batch = '{32'd7};
        run_phase(5'd16, 64'h3736_3534_3332_3130, 64'h2D65_6463_6261_3938);
        batch = '{32'd123};
        run_phase(5'd5, 64'h0000_0041_4443_4241, 64'h0);

        for (int ph = 0; ph < 10; ph++) begin
            valid = !(ph == 2 || ph == 6);
            make_alphabet(valid, radix, lo, hi);
            batch = {};
            repeat (23) batch.push_back(pick_value(radix));
            run_phase(radix, lo, hi);
        end

        $display("ran %0d values over %0d alphabet settings, %0d dropped as unprintable",
                 text_check.values_seen, settings_used, text_check.values_dropped);
        $display("checked %0d text bytes, %0d mismatches",
                 text_check.chars_checked, text_check.errors);
        if (text_check.errors == 0)
            $display("signed_int_to_radix_text verification clean");
        else
            $display("signed_int_to_radix_text verification failed");
        $finish;
    end

endmodule
